// ===== rtl/ipcd_pkg.sv =====
// Shared constants, types and sine table for the inverse Park/Clarke PWM duty block.
package ipcd_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int ANGLE_BITS       = 16;

    localparam int DEPTH_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER    = SINE_TABLE_DEPTH / 4;
    localparam int QIDX_W     = DEPTH_BITS - 1;

    localparam int UQ_W       = 16;
    localparam int ANGLE_W    = 16;
    localparam int DUTY_W     = 16;
    localparam int OFFSET_W   = 16;
    localparam int SUPPLY_W   = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_TDATA_W  = UQ_W + ANGLE_W;
    localparam int OUT_TDATA_W = 3 * DUTY_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_EN    = 2'd2;

    localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 15'd12288;

    localparam int SINE_W    = 16;
    localparam int PROD_W    = 32;
    localparam int P_W       = 48;
    localparam int H_W       = 35;
    localparam int REM_W     = SUPPLY_W + DUTY_W;
    localparam int DIV_BITS  = DUTY_W;
    localparam int FE_STAGES = 5;

    localparam logic signed [18:0] SQRT3_Q16 = 19'sd113512;

    localparam longint unsigned Q_STEP = 64'h1_0000_0000 / SINE_TABLE_DEPTH;

    typedef logic [SINE_W-1:0] t_sine_rom [0:QUARTER];

    typedef struct packed {
        logic signed [H_W-1:0] h_c;
        logic signed [H_W-1:0] h_b;
        logic signed [H_W-1:0] h_a;
    } t_phase_h;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_c;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_a;
    } t_duty;

    function automatic longint unsigned quarter_sine(input longint unsigned q);
        longint unsigned x2;
        longint unsigned s;
        x2 = (q * q) >> 30;
        s  = 64'd172273;
        s  = 64'd5026995 - ((s * x2) >> 30);
        s  = 64'd85569306 - ((s * x2) >> 30);
        s  = 64'd693598668 - ((s * x2) >> 30);
        s  = 64'd1686629713 - ((s * x2) >> 30);
        return (s * q) >> 30;
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom       rom;
        longint unsigned r;
        int              i;
        for (i = 0; i <= QUARTER; i++) begin
            r = (quarter_sine(64'(i) * Q_STEP) + 64'd16384) >> 15;
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            rom[i] = SINE_W'(r);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/ipcd_div.sv =====
// Pipelined clamp and restoring divide by supply, one quotient bit per stage, three lanes.
module ipcd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ipcd_pkg::SUPPLY_W-1:0]  i_supply,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  ipcd_pkg::t_phase_h             i_h,
    output logic                           o_valid,
    input  logic                           i_ready,
    output ipcd_pkg::t_duty                o_duty
);
    import ipcd_pkg::*;

    logic [DIV_BITS:0]     r_v;
    logic [DIV_BITS:0]     w_en;
    logic [REM_W-1:0]      r_rem [0:2][0:DIV_BITS-1];
    logic [DUTY_W-1:0]     r_q   [0:2][0:DIV_BITS-1];
    logic                  r_sat [0:2][0:DIV_BITS-1];
    logic [DUTY_W-1:0]     r_duty [0:2];
    logic signed [H_W-1:0] w_h [0:2];
    logic [REM_W-1:0]      w_top;

    assign w_h[0] = i_h.h_a;
    assign w_h[1] = i_h.h_b;
    assign w_h[2] = i_h.h_c;
    assign w_top  = {i_supply, {DUTY_W{1'b0}}};

    always_comb begin
        w_en[DIV_BITS] = !r_v[DIV_BITS] || i_ready;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i <= DIV_BITS; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        // clamp to 0..supply*2^16, flag the full-scale case
        always_ff @(posedge i_clk) begin
            if (w_en[0]) begin
                r_q[l][0] <= '0;
                if (w_h[l] < 0) begin
                    r_rem[l][0] <= '0;
                    r_sat[l][0] <= 1'b0;
                end else if (w_h[l] >= $signed({{(H_W-REM_W){1'b0}}, w_top})) begin
                    r_rem[l][0] <= w_top;
                    r_sat[l][0] <= 1'b1;
                end else begin
                    r_rem[l][0] <= w_h[l][REM_W-1:0];
                    r_sat[l][0] <= 1'b0;
                end
            end
        end

        for (genvar j = 1; j <= DIV_BITS; j++) begin : g_step
            logic [REM_W-1:0] w_d;
            logic             w_ge;
            assign w_d  = REM_W'(i_supply) << (DIV_BITS - j);
            assign w_ge = r_rem[l][j-1] >= w_d;
            if (j < DIV_BITS) begin : g_mid
                always_ff @(posedge i_clk) begin
                    if (w_en[j]) begin
                        r_rem[l][j] <= w_ge ? r_rem[l][j-1] - w_d : r_rem[l][j-1];
                        r_q[l][j]   <= {r_q[l][j-1][DUTY_W-2:0], w_ge};
                        r_sat[l][j] <= r_sat[l][j-1];
                    end
                end
            end else begin : g_last
                always_ff @(posedge i_clk) begin
                    if (w_en[j]) begin
                        if (i_supply == '0) begin
                            r_duty[l] <= '0;
                        end else if (r_sat[l][j-1]) begin
                            r_duty[l] <= '1;
                        end else begin
                            r_duty[l] <= {r_q[l][j-1][DUTY_W-2:0], w_ge};
                        end
                    end
                end
            end
        end
    end

    assign o_duty.duty_a = r_duty[0];
    assign o_duty.duty_b = r_duty[1];
    assign o_duty.duty_c = r_duty[2];

endmodule

// ===== rtl/inverse_park_clarke_pwm_duty_top.sv =====
// Top level: config registers, angle/sine/transform pipeline and duty divider.
// Converts a quadrature voltage command and electrical angle into three Q0.16 PWM duties
// (inverse Park with Ud = 0, inverse Clarke around half supply, clamp and divide by supply).
// One beat is accepted every clock unless back-pressure fills the pipeline; the path has
// five transform stages, one phase clamp stage and the sixteen-stage restoring divider that
// produces one quotient bit per stage. Downstream stalls back up through the pipeline; empty
// stages still take input. Write the configuration only while no beat is in flight.
module inverse_park_clarke_pwm_duty_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ipcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ipcd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ipcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // uq, angle
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ipcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // duty_a, duty_b, duty_c
);
    import ipcd_pkg::*;

    logic [OFFSET_W-1:0] r_zero_offset;
    logic [SUPPLY_W-1:0] r_supply;
    logic                r_clamp_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
            r_supply      <= SUPPLY_RESET;
            r_clamp_en    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZERO_OFFSET: r_zero_offset <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_SUPPLY:      r_supply      <= i_cfg_wdata[SUPPLY_W-1:0];
                CFG_CLAMP_EN:    r_clamp_en    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [SINE_W:0] turn_sine(input logic [DEPTH_BITS-1:0] t);
        logic [1:0]            quad;
        logic [DEPTH_BITS-3:0] j;
        logic [QIDX_W-1:0]     idx;
        logic [SINE_W:0]       mag;
        quad = t[DEPTH_BITS-1 -: 2];
        j    = t[DEPTH_BITS-3:0];
        idx  = quad[0] ? QIDX_W'(QUARTER) - {1'b0, j} : {1'b0, j};
        mag  = {1'b0, SINE_ROM[idx]};
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    logic [FE_STAGES-1:0] r_fv;
    logic [FE_STAGES-1:0] w_fen;
    logic                 w_div_ready;

    always_comb begin
        w_fen[FE_STAGES-1] = !r_fv[FE_STAGES-1] || w_div_ready;
        for (int i = FE_STAGES - 2; i >= 0; i--) begin
            w_fen[i] = !r_fv[i] || w_fen[i+1];
        end
    end

    assign s_axis_tready = w_fen[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            if (w_fen[0]) begin
                r_fv[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < FE_STAGES; i++) begin
                if (w_fen[i]) begin
                    r_fv[i] <= r_fv[i-1];
                end
            end
        end
    end

    // stage 0: uq clamp, angle offset and sine index
    logic signed [UQ_W-1:0]             w_uq;
    logic [ANGLE_W-1:0]                 w_angle;
    logic signed [UQ_W-1:0]             w_half;
    logic signed [UQ_W-1:0]             w_uq_c;
    logic [31:0]                        w_ang_sum;
    logic [ANGLE_BITS-1:0]              w_e;
    logic [ANGLE_BITS+DEPTH_BITS-1:0]   w_kw;
    logic signed [UQ_W-1:0]             r_uq0;
    logic [DEPTH_BITS-1:0]              r_k0;

    assign w_uq      = $signed(s_axis_tdata[UQ_W-1:0]);
    assign w_angle   = s_axis_tdata[UQ_W +: ANGLE_W];
    assign w_half    = $signed({2'b00, r_supply[SUPPLY_W-1:1]});
    assign w_ang_sum = 32'(w_angle) + 32'(r_zero_offset);
    assign w_e       = w_ang_sum[ANGLE_BITS-1:0];
    assign w_kw      = {w_e, {DEPTH_BITS{1'b0}}};

    always_comb begin
        w_uq_c = w_uq;
        if (r_clamp_en) begin
            if (w_uq > w_half) begin
                w_uq_c = w_half;
            end else if (w_uq < -w_half) begin
                w_uq_c = -w_half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fen[0]) begin
            r_uq0 <= w_uq_c;
            r_k0  <= w_kw[ANGLE_BITS +: DEPTH_BITS];
        end
    end

    // stage 1: sine and cosine lookup
    logic signed [SINE_W:0] r_sn1;
    logic signed [SINE_W:0] r_cs1;
    logic signed [UQ_W-1:0] r_uq1;

    always_ff @(posedge i_clk) begin
        if (w_fen[1]) begin
            r_sn1 <= turn_sine(r_k0);
            r_cs1 <= turn_sine(r_k0 + DEPTH_BITS'(QUARTER));
            r_uq1 <= r_uq0;
        end
    end

    // stage 2: uq * sin, uq * cos
    logic signed [PROD_W:0]   w_ps;
    logic signed [PROD_W:0]   w_pc;
    logic signed [PROD_W-1:0] r_ps2;
    logic signed [PROD_W-1:0] r_b2;

    assign w_ps = r_uq1 * r_sn1;
    assign w_pc = r_uq1 * r_cs1;

    always_ff @(posedge i_clk) begin
        if (w_fen[2]) begin
            r_ps2 <= w_ps[PROD_W-1:0];
            r_b2  <= w_pc[PROD_W-1:0];
        end
    end

    // stage 3: alpha and sqrt(3) * beta
    logic signed [P_W-1:0]    w_p;
    logic signed [PROD_W-1:0] r_a3;
    logic signed [P_W-1:0]    r_p3;

    assign w_p = r_b2 * SQRT3_Q16;

    always_ff @(posedge i_clk) begin
        if (w_fen[3]) begin
            r_a3 <= -r_ps2;
            r_p3 <= w_p;
        end
    end

    // stage 4: phase voltages in units of 2^16
    logic signed [H_W-1:0] w_mid;
    logic signed [H_W-1:0] w_a_x;
    logic signed [P_W-1:0] w_np;
    logic signed [H_W-1:0] w_pq_x;
    logic signed [H_W-1:0] w_nq_x;
    t_phase_h              r_h4;

    assign w_mid  = $signed({{(H_W-SUPPLY_W-15){1'b0}}, r_supply, 15'd0});
    assign w_a_x  = {{(H_W-PROD_W){r_a3[PROD_W-1]}}, r_a3};
    assign w_np   = -r_p3;
    assign w_pq_x = {{(H_W-P_W+16){r_p3[P_W-1]}}, r_p3[P_W-1:16]};
    assign w_nq_x = {{(H_W-P_W+16){w_np[P_W-1]}}, w_np[P_W-1:16]};

    always_ff @(posedge i_clk) begin
        if (w_fen[4]) begin
            r_h4.h_a <= (w_a_x <<< 1) + w_mid;
            r_h4.h_b <= w_pq_x - w_a_x + w_mid;
            r_h4.h_c <= w_nq_x - w_a_x + w_mid;
        end
    end

    t_duty w_duty;

    ipcd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_supply (r_supply),
        .i_valid  (r_fv[FE_STAGES-1]),
        .o_ready  (w_div_ready),
        .i_h      (r_h4),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_duty   (w_duty)
    );

    assign m_axis_tdata = w_duty;

endmodule

// ===== rtl/ipcd_chk.sv =====
// Port-level checker for the inverse Park/Clarke PWM duty block, bound to the top level.
module ipcd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [ipcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ipcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import ipcd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("stalled input beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked output beat");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !s_axis_tvalid && !m_axis_tvalid)
        else $error("config write with a beat in flight");

endmodule

bind inverse_park_clarke_pwm_duty_top ipcd_chk u_ipcd_chk (.*);
